### rtl/core/tqpa_pkg.sv
// Package for the two-queue priority arbiter core.
// Holds shared constants, entry type, status codes and the beats compare; no dependencies.
package tqpa_pkg;

    localparam int QueueDepthDefault = 16;
    localparam logic [3:0] StreakLimitReset = 4'd3;
    localparam logic [3:0] StreakMax = 4'd15;

    localparam logic SIDE_EAST = 1'b0;
    localparam logic SIDE_WEST = 1'b1;

    localparam logic [1:0] LAST_NONE = 2'd0;
    localparam logic [1:0] LAST_EAST = 2'd1;
    localparam logic [1:0] LAST_WEST = 2'd2;

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    localparam logic KIND_ENQUEUE = 1'b0;
    localparam logic KIND_GRANT = 1'b1;

    typedef struct packed {
        logic       high;
        logic [7:0] arrival;
        logic [7:0] id;
    } t_entry;

    // a beats b: higher priority, or same priority and arrival with smaller id
    function automatic logic beats(t_entry a, t_entry b);
        logic r;
        r = (a.high && !b.high) ||
            (a.high == b.high && a.arrival == b.arrival && a.id < b.id);
        return r;
    endfunction

endpackage

### rtl/core/tqpa_if.sv
// Request and result channel interfaces with valid/ready handshake.
// Depends on nothing.
interface tqpa_req_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic       direction;
    logic       high_priority;
    logic [7:0] entry_id;
    logic [7:0] arrival;
    modport source (output valid, kind, direction, high_priority, entry_id, arrival,
                    input ready);
    modport sink (input valid, kind, direction, high_priority, entry_id, arrival,
                  output ready);
endinterface

interface tqpa_res_if;
    logic       valid;
    logic       ready;
    logic       granted;
    logic [7:0] grant_id;
    logic       grant_side;
    logic       grant_high;
    logic [1:0] status;
    modport source (output valid, granted, grant_id, grant_side, grant_high, status,
                    input ready);
    modport sink (input valid, granted, grant_id, grant_side, grant_high, status,
                  output ready);
endinterface

### rtl/core/tqpa_queue_mem.sv
// One queue store: synchronous RAM with one write and one read port, read data registered.
// Depends on tqpa_pkg.
module tqpa_queue_mem #(
    parameter int DEPTH = tqpa_pkg::QueueDepthDefault,
    parameter int AW = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  tqpa_pkg::t_entry     i_wdata,
    input  logic [AW-1:0]        i_raddr,
    output tqpa_pkg::t_entry     o_rdata
);
    import tqpa_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/core/two_queue_priority_arbiter_core.sv
// Top level of the two-queue priority arbiter: sequencer plus two queue RAMs.
// Depends on tqpa_pkg, tqpa_if and tqpa_queue_mem.
//
//  channel   dir  handshake      payload
//  i_req     in   valid/ready    kind, direction, high_priority, entry_id, arrival
//  o_res     out  valid/ready    granted, grant_id, grant_side, grant_high, status
//  cfg       in   i_cfg_we       i_cfg_wdata (streak_limit)
//
// An enqueue into a queue scans one entry per cycle up to the insertion point,
// shifts the tail up one entry per cycle, then writes the new entry and loads
// the result. A grant reads both heads, picks a side, then shifts the served
// queue down over the popped head. A full drop or a grant with both queues empty
// loads its result at acceptance. Each queue RAM has a single read port. Reset is
// synchronous; the queues need no clearing. A pending result holds off the next
// request until taken.
module two_queue_priority_arbiter_core #(
    parameter int QUEUE_DEPTH = tqpa_pkg::QueueDepthDefault
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    tqpa_req_if.sink             i_req,
    tqpa_res_if.source           o_res,
    input  logic                 i_cfg_we,
    input  logic [3:0]           i_cfg_wdata
);
    import tqpa_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DepthC = CW'(QUEUE_DEPTH);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1; // read issued at r_pos
    localparam logic [2:0] ST_SHR   = 3'd2; // insert shift: read issued at r_idx-1
    localparam logic [2:0] ST_HEADS = 3'd3; // both head reads issued
    localparam logic [2:0] ST_POP   = 3'd4; // pop shift: read issued at r_idx+1
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]    r_state;
    logic [3:0]    r_limit;
    logic [CW-1:0] r_cnt_e, r_cnt_w;
    logic [1:0]    r_last;
    logic [3:0]    r_streak;
    logic          r_side;
    t_entry        r_ent;
    logic [CW-1:0] r_pos;
    logic [CW-1:0] r_idx;
    logic          r_ins_fin; // pending write of new entry at r_pos

    logic          r_ovalid, n_ovalid;
    logic          r_ogranted;
    logic [7:0]    r_oid;
    logic          r_oside;
    logic          r_ohigh;
    logic [1:0]    r_ostatus;

    // RAM ports
    logic          we_e, we_w;
    logic [AW-1:0] waddr, raddr_e, raddr_w;
    t_entry        wdata, rd_e, rd_w, rd_s;
    logic [CW-1:0] cnt_s;

    tqpa_queue_mem #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_east (
        .i_clk(i_clk), .i_we(we_e), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr_e), .o_rdata(rd_e));
    tqpa_queue_mem #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_west (
        .i_clk(i_clk), .i_we(we_w), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr_w), .o_rdata(rd_w));

    assign rd_s  = r_side ? rd_w : rd_e;
    assign cnt_s = r_side ? r_cnt_w : r_cnt_e;
    assign i_req.ready = (r_state == ST_IDLE) && !r_ovalid;

    logic accept;
    assign accept = i_req.valid && i_req.ready;

    logic [CW-1:0] req_cnt;
    assign req_cnt = i_req.direction ? r_cnt_w : r_cnt_e;

    // grant side decision from the two registered heads
    logic pick;
    always_comb begin
        if (r_cnt_e == '0) begin
            pick = SIDE_WEST;
        end else if (r_cnt_w == '0) begin
            pick = SIDE_EAST;
        end else if (r_streak < r_limit && rd_w.high && !rd_e.high) begin
            pick = SIDE_WEST;
        end else if (r_streak < r_limit && !rd_w.high && rd_e.high) begin
            pick = SIDE_EAST;
        end else begin
            pick = (r_last == LAST_WEST) ? SIDE_EAST : SIDE_WEST;
        end
    end

    // load the result register on a finished request, hold it until taken
    logic res_set;
    assign res_set = (r_state == ST_OUT) ||
                     (accept && i_req.kind == KIND_GRANT &&
                      r_cnt_e == '0 && r_cnt_w == '0) ||
                     (accept && i_req.kind == KIND_ENQUEUE && req_cnt >= DepthC);
    assign n_ovalid = res_set || (r_ovalid && !o_res.ready);

    // read address and write control
    logic          wr;
    logic          rside;
    logic [CW-1:0] rad;
    always_comb begin
        wr    = 1'b0;
        rside = r_side;
        waddr = r_idx[AW-1:0];
        wdata = r_ent;
        rad   = '0;
        case (r_state)
            ST_IDLE: begin
                // park both read ports on the heads
                rad = '0;
            end
            ST_SCAN: begin
                // rd_s holds entry r_pos
                if (beats(r_ent, rd_s)) begin
                    // shift tail upward starting at cnt-1
                    rad = cnt_s - 1'b1;
                end else begin
                    rad = r_pos + 1'b1;
                end
            end
            ST_SHR: begin
                // rd_s holds entry r_idx-1, move it to r_idx
                wr    = 1'b1;
                wdata = rd_s;
                rad   = r_idx - 2'd2;
            end
            ST_HEADS: begin
                // fetch entry 1 of the side being served
                rside = pick;
                rad   = CW'(1);
            end
            ST_POP: begin
                // rd_s holds entry r_idx+1, move it to r_idx
                wr    = 1'b1;
                wdata = rd_s;
                rad   = r_idx + 2'd2;
            end
            ST_OUT: begin
                // final write of new entry at r_pos during insert
                wr    = r_ins_fin;
                waddr = r_pos[AW-1:0];
            end
            default: ;
        endcase
    end
    assign raddr_e = (rside == SIDE_EAST) ? rad[AW-1:0] : '0;
    assign raddr_w = (rside == SIDE_WEST) ? rad[AW-1:0] : '0;
    assign we_e = wr && (r_side == SIDE_EAST);
    assign we_w = wr && (r_side == SIDE_WEST);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_limit   <= StreakLimitReset;
            r_cnt_e   <= '0;
            r_cnt_w   <= '0;
            r_last    <= LAST_NONE;
            r_streak  <= '0;
            r_ovalid  <= 1'b0;
            r_ins_fin <= 1'b0;
        end else begin
            if (i_cfg_we) r_limit <= i_cfg_wdata;
            r_ovalid <= n_ovalid;
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_side     <= i_req.direction;
                        r_ent      <= '{high: i_req.high_priority,
                                        arrival: i_req.arrival,
                                        id: i_req.entry_id};
                        r_pos      <= '0;
                        r_ogranted <= 1'b0;
                        r_oid      <= '0;
                        r_oside    <= 1'b0;
                        r_ohigh    <= 1'b0;
                        r_ostatus  <= STATUS_OK;
                        if (i_req.kind == KIND_GRANT) begin
                            if (r_cnt_e == '0 && r_cnt_w == '0) begin
                                r_ostatus <= STATUS_EMPTY;
                            end else begin
                                r_state <= ST_HEADS;
                            end
                        end else if (req_cnt >= DepthC) begin
                            r_ostatus <= STATUS_FULL;
                        end else if (req_cnt == '0) begin
                            r_ins_fin <= 1'b1;
                            r_state   <= ST_OUT;
                        end else begin
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (beats(r_ent, rd_s)) begin
                        r_idx   <= cnt_s;
                        r_state <= ST_SHR;
                    end else if (r_pos + 1'b1 == cnt_s) begin
                        // append at the tail
                        r_pos     <= cnt_s;
                        r_ins_fin <= 1'b1;
                        r_state   <= ST_OUT;
                    end else begin
                        r_pos <= r_pos + 1'b1;
                    end
                end
                ST_SHR: begin
                    if (r_idx - 1'b1 == r_pos) begin
                        r_ins_fin <= 1'b1;
                        r_state   <= ST_OUT;
                    end else begin
                        r_idx <= r_idx - 1'b1;
                    end
                end
                ST_HEADS: begin
                    r_side     <= pick;
                    r_ogranted <= 1'b1;
                    r_oid      <= pick ? rd_w.id : rd_e.id;
                    r_ohigh    <= pick ? rd_w.high : rd_e.high;
                    r_oside    <= pick;
                    r_last     <= pick ? LAST_WEST : LAST_EAST;
                    if (r_last == (pick ? LAST_WEST : LAST_EAST)) begin
                        r_streak <= (r_streak < StreakMax) ? r_streak + 1'b1 : StreakMax;
                    end else begin
                        r_streak <= 4'd1;
                    end
                    r_idx <= '0;
                    if ((pick ? r_cnt_w : r_cnt_e) > 1) begin
                        r_state <= ST_POP; // read of index 1 issued above
                    end else begin
                        r_state <= ST_OUT;
                    end
                    if (pick) r_cnt_w <= r_cnt_w - 1'b1;
                    else      r_cnt_e <= r_cnt_e - 1'b1;
                end
                ST_POP: begin
                    // cnt_s already holds the count after the pop
                    if (r_idx + 1'b1 >= cnt_s) begin
                        r_state <= ST_OUT;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_OUT: begin
                    if (r_ins_fin) begin
                        if (r_side) r_cnt_w <= r_cnt_w + 1'b1;
                        else        r_cnt_e <= r_cnt_e + 1'b1;
                    end
                    r_ins_fin <= 1'b0;
                    r_state   <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_res.valid      = r_ovalid;
    assign o_res.granted    = r_ogranted;
    assign o_res.grant_id   = r_oid;
    assign o_res.grant_side = r_oside;
    assign o_res.grant_high = r_ohigh;
    assign o_res.status     = r_ostatus;
endmodule

### rtl/core/tqpa_checker.sv
// Port-level checker for the arbiter core, bound to the top level.
// Depends on tqpa_pkg and the top level's ports.
module tqpa_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       req_ready,
    input logic       res_valid,
    input logic       res_ready,
    input logic       res_granted,
    input logic [1:0] res_status
);
    import tqpa_pkg::*;

    // a result never stays valid while a new request is taken
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> !req_ready) else $error("request taken while result pending");

    // granted results always report ok
    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && res_granted |-> res_status == STATUS_OK)
        else $error("granted result with bad status");

    // status code in range
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> res_status <= STATUS_EMPTY) else $error("bad status code");

    // held result stays until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && !res_ready |=> res_valid) else $error("result dropped");
endmodule

bind two_queue_priority_arbiter_core tqpa_checker u_tqpa_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .req_ready(i_req.ready),
    .res_valid(o_res.valid), .res_ready(o_res.ready),
    .res_granted(o_res.granted), .res_status(o_res.status));

### bench/tqpa_tb_pkg.sv
`timescale 1ns / 1ps
// Request table type used by the arbiter testbench.
// Depends on tqpa_pkg for the field codes.
package tqpa_tb_pkg;
    import tqpa_pkg::*;

    // One directed request; check_fixed marks rows with a hand-written result.
    typedef struct {
        logic       kind;
        logic       direction;
        logic       high;
        logic [7:0] id;
        logic [7:0] arrival;
        bit         check_fixed;
        logic       granted;
        logic [7:0] grant_id;
        logic       grant_side;
        logic       grant_high;
        logic [1:0] status;
    } t_row;
endpackage

### bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for two_queue_priority_arbiter_core: directed table, east fill and drain,
// then random traffic, each result checked against an in-bench queue/arbitration model.
// Depends on tqpa_pkg, tqpa_tb_pkg, tqpa_if and the core.
module testbench;
    import tqpa_pkg::*;
    import tqpa_tb_pkg::*;

    localparam int Depth = 16;
    localparam int DrainCycles = 80;

    typedef struct {
        logic       granted;
        logic [7:0] grant_id;
        logic       grant_side;
        logic       grant_high;
        logic [1:0] status;
    } t_grant;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [3:0] i_cfg_wdata;
    bit failed;

    tqpa_req_if req_if ();
    tqpa_res_if res_if ();

    two_queue_priority_arbiter_core #(.QUEUE_DEPTH(Depth)) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_req(req_if.sink),
        .o_res(res_if.source),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    // Arbiter model state
    t_entry east_q[$];
    t_entry west_q[$];
    logic [1:0] last_served;
    logic [3:0] streak;
    logic [3:0] limit;
    t_grant pending_grants[$];

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Insert ahead of the first entry the new one beats.
    function automatic bit insert_entry(ref t_entry q[$], input t_entry e);
        int pos;
        if (q.size() >= Depth) return 1'b0;
        pos = 0;
        while (pos < q.size() && !((e.high && !q[pos].high) ||
               (e.high == q[pos].high && e.arrival == q[pos].arrival &&
                e.id < q[pos].id)))
            pos++;
        q.insert(pos, e);
        return 1'b1;
    endfunction

    function automatic t_grant arbitrate(logic kind, logic dir, logic high,
                                         logic [7:0] id, logic [7:0] lt);
        t_grant g;
        t_entry e;
        logic side;
        g = '{default: '0};
        if (kind == KIND_ENQUEUE) begin
            e.high = high;
            e.arrival = lt;
            e.id = id;
            if (dir == SIDE_WEST) g.status = insert_entry(west_q, e) ? STATUS_OK : STATUS_FULL;
            else g.status = insert_entry(east_q, e) ? STATUS_OK : STATUS_FULL;
            return g;
        end
        if (east_q.size() == 0 && west_q.size() == 0) begin
            g.status = STATUS_EMPTY;
            return g;
        end
        if (east_q.size() == 0) side = SIDE_WEST;
        else if (west_q.size() == 0) side = SIDE_EAST;
        else if (streak < limit && west_q[0].high && !east_q[0].high) side = SIDE_WEST;
        else if (streak < limit && !west_q[0].high && east_q[0].high) side = SIDE_EAST;
        else side = (last_served == LAST_WEST) ? SIDE_EAST : SIDE_WEST;
        // Advance the streak count
        if (last_served == ((side == SIDE_WEST) ? LAST_WEST : LAST_EAST))
            streak = (streak < StreakMax) ? streak + 4'd1 : StreakMax;
        else
            streak = 4'd1;
        last_served = (side == SIDE_WEST) ? LAST_WEST : LAST_EAST;
        e = (side == SIDE_WEST) ? west_q.pop_front() : east_q.pop_front();
        g.granted = 1'b1;
        g.grant_id = e.id;
        g.grant_side = side;
        g.grant_high = e.high;
        return g;
    endfunction

    // Result side: random stall on ready, compare against oldest expectation.
    int stall;
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                stall--;
                res_if.ready = 1'b0;
            end else begin
                res_if.ready = 1'b1;
                stall = ($urandom_range(0, 9) < 6) ? 0 :
                        ($urandom_range(0, 19) == 0 ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 4));
            end
        end
    end

    always @(posedge i_clk) begin
        t_grant x;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_grants.size() == 0) begin
                $error("result with nothing expected");
                failed = 1'b1;
            end else begin
                x = pending_grants.pop_front();
                if (res_if.granted !== x.granted) begin
                    $error("granted: expected %0d, got %0d", x.granted, res_if.granted);
                    failed = 1'b1;
                end
                if (res_if.grant_id !== x.grant_id) begin
                    $error("grant_id: expected %0d, got %0d", x.grant_id, res_if.grant_id);
                    failed = 1'b1;
                end
                if (res_if.grant_side !== x.grant_side) begin
                    $error("grant_side: expected %0d, got %0d", x.grant_side,
                           res_if.grant_side);
                    failed = 1'b1;
                end
                if (res_if.grant_high !== x.grant_high) begin
                    $error("grant_high: expected %0d, got %0d", x.grant_high,
                           res_if.grant_high);
                    failed = 1'b1;
                end
                if (res_if.status !== x.status) begin
                    $error("status: expected %0d, got %0d", x.status, res_if.status);
                    failed = 1'b1;
                end
            end
        end
    end

    // Drive one request and queue its expected result at acceptance.
    task automatic send_request(logic kind, logic dir, logic high, logic [7:0] id,
                                logic [7:0] lt, bit fixed, t_grant want);
        t_grant g;
        int gap;
        if ($urandom_range(0, 2) != 0) begin
            gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                               : $urandom_range(1, 3);
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid = 1'b1;
        req_if.kind = kind;
        req_if.direction = dir;
        req_if.high_priority = high;
        req_if.entry_id = id;
        req_if.arrival = lt;
        do @(posedge i_clk); while (!req_if.ready);
        g = arbitrate(kind, dir, high, id, lt);
        if (fixed) g = want;
        pending_grants.push_back(g);
        @(negedge i_clk);
        req_if.valid = 1'b0;
    endtask

    task automatic drain_results();
        while (pending_grants.size() != 0) @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);
    endtask

    task automatic write_limit(logic [3:0] value);
        drain_results();
        i_cfg_we = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        limit = value;
    endtask

    // Directed table: fixed results only where obvious.
    t_row directed[] = '{
        '{KIND_GRANT, SIDE_EAST, 1'b0, 8'd0, 8'd0,
          1'b1, 1'b0, 8'd0, 1'b0, 1'b0, STATUS_EMPTY},
        '{KIND_ENQUEUE, SIDE_EAST, 1'b0, 8'd255, 8'd255,
          1'b1, 1'b0, 8'd0, 1'b0, 1'b0, STATUS_OK},
        '{KIND_GRANT, SIDE_WEST, 1'b1, 8'd255, 8'd255,
          1'b1, 1'b1, 8'd255, SIDE_EAST, 1'b0, STATUS_OK},
        '{KIND_ENQUEUE, SIDE_WEST, 1'b1, 8'd0, 8'd0,
          1'b1, 1'b0, 8'd0, 1'b0, 1'b0, STATUS_OK},
        '{KIND_GRANT, SIDE_EAST, 1'b0, 8'd0, 8'd0,
          1'b1, 1'b1, 8'd0, SIDE_WEST, 1'b1, STATUS_OK},
        '{KIND_ENQUEUE, SIDE_EAST, 1'b0, 8'd20, 8'd5,
          1'b0, 1'b0, 8'd0, 1'b0, 1'b0, STATUS_OK},
        '{KIND_ENQUEUE, SIDE_EAST, 1'b0, 8'd10, 8'd5,
          1'b0, 1'b0, 8'd0, 1'b0, 1'b0, STATUS_OK},
        '{KIND_ENQUEUE, SIDE_EAST, 1'b1, 8'd30, 8'd9,
          1'b0, 1'b0, 8'd0, 1'b0, 1'b0, STATUS_OK},
        '{KIND_ENQUEUE, SIDE_WEST, 1'b0, 8'd7, 8'd1,
          1'b0, 1'b0, 8'd0, 1'b0, 1'b0, STATUS_OK},
        '{KIND_ENQUEUE, SIDE_WEST, 1'b1, 8'd8, 8'd1,
          1'b0, 1'b0, 8'd0, 1'b0, 1'b0, STATUS_OK},
        '{KIND_GRANT, SIDE_EAST, 1'b0, 8'd0, 8'd0,
          1'b0, 1'b0, 8'd0, 1'b0, 1'b0, STATUS_OK},
        '{KIND_GRANT, SIDE_EAST, 1'b0, 8'd0, 8'd0,
          1'b0, 1'b0, 8'd0, 1'b0, 1'b0, STATUS_OK},
        '{KIND_GRANT, SIDE_EAST, 1'b0, 8'd0, 8'd0,
          1'b0, 1'b0, 8'd0, 1'b0, 1'b0, STATUS_OK},
        '{KIND_GRANT, SIDE_EAST, 1'b0, 8'd0, 8'd0,
          1'b0, 1'b0, 8'd0, 1'b0, 1'b0, STATUS_OK},
        '{KIND_GRANT, SIDE_EAST, 1'b0, 8'd0, 8'd0,
          1'b0, 1'b0, 8'd0, 1'b0, 1'b0, STATUS_OK},
        '{KIND_GRANT, SIDE_EAST, 1'b0, 8'd0, 8'd0,
          1'b1, 1'b0, 8'd0, 1'b0, 1'b0, STATUS_EMPTY}
    };

    initial begin
        int n;
        int burst;
        logic dir;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        req_if.valid = 1'b0;
        req_if.kind = KIND_ENQUEUE;
        req_if.direction = SIDE_EAST;
        req_if.high_priority = 1'b0;
        req_if.entry_id = '0;
        req_if.arrival = '0;
        last_served = LAST_NONE;
        streak = '0;
        limit = StreakLimitReset;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Walk the directed table at the reset limit
        foreach (directed[i])
            send_request(directed[i].kind, directed[i].direction, directed[i].high,
                         directed[i].id, directed[i].arrival, directed[i].check_fixed,
                         '{directed[i].granted, directed[i].grant_id,
                           directed[i].grant_side, directed[i].grant_high,
                           directed[i].status});

        // Fill east to overflow, then drain past empty
        for (int i = 0; i < Depth + 2; i++)
            send_request(KIND_ENQUEUE, SIDE_EAST, i[0], 8'(i * 13), 8'(i % 3), 0, '{default: '0});
        for (int i = 0; i < Depth + 1; i++)
            send_request(KIND_GRANT, 1'b0, 1'b0, 8'd0, 8'd0, 0, '{default: '0});

        // Random phases across limit settings, extremes included
        n = 0;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: write_limit(4'd0);
                1: write_limit(4'd1);
                2: write_limit(4'd15);
                3: write_limit(4'd7);
                default: write_limit(StreakLimitReset);
            endcase
            for (int k = 0; k < 140; ) begin
                // Bursts of random requests, about 60 percent enqueues and 40 percent grants
                burst = $urandom_range(1, 6);
                for (int b = 0; b < burst && k < 140; b++, k++) begin
                    dir = 1'($urandom_range(0, 1));
                    send_request(($urandom_range(0, 9) < 4) ? KIND_GRANT : KIND_ENQUEUE,
                                 dir, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                                 ($urandom_range(0, 1) ? 8'($urandom_range(0, 3))
                                                       : 8'($urandom_range(0, 255))),
                                 0, '{default: '0});
                end
                n++;
                if (n == 40) drain_results();
            end
        end

        drain_results();
        if (!failed) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

### files.f
rtl/core/tqpa_pkg.sv
rtl/core/tqpa_if.sv
rtl/core/tqpa_queue_mem.sv
rtl/core/two_queue_priority_arbiter_core.sv
rtl/core/tqpa_checker.sv
bench/tqpa_tb_pkg.sv
bench/testbench.sv
